[src/fdc_pkg.sv]
package fdc_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int MAX_PAYLOAD_DEF  = 52;
    localparam int HDR_BYTES        = 10;
    localparam int OVERHEAD_BYTES   = 12;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  VER_ONE  = 8'h01;
    localparam logic [7:0]  VER_TWO  = 8'h02;
    localparam logic [7:0]  TYPE_MIN = 8'h01;
    localparam logic [7:0]  TYPE_MAX = 8'h03;

    localparam logic [1:0] CFG_SOF0  = 2'd0;
    localparam logic [1:0] CFG_SOF1  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_HDR_RD,
        ST_HDR_CHK,
        ST_CRC_RD,
        ST_CRC_BYTE,
        ST_CRC_CHK,
        ST_OUT_RD,
        ST_OUT_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;        // append the accepted byte (drop oldest if full)
        logic cap_prev;    // latch read data as previous byte
        logic idx_clr;     // index := 0
        logic idx_inc;     // index := index + 1
        logic drop_idx;    // drop index bytes from the front (one fewer on a pair hit)
        logic drop_one;
        logic drop_two;
        logic drop_total;
        logic hdr_cap;     // latch header byte at index
        logic crc_init;
        logic crc_byte;    // fold read data into the crc, or latch a received crc byte
        logic err_inc;
        logic out_load;    // present payload byte
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;    // index + 1 >= count (scan end)
        logic pair_hit;    // prev and current byte form the start pair
        logic hdr_done;    // index reached last header byte
        logic few_hdr;     // count below header size
        logic sane;
        logic complete;    // whole frame buffered
        logic crc_done;    // index reached end of crc span
        logic crc_ok;
        logic out_last;
        logic none_out;    // delivery count is zero
    } t_sts;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

endpackage

[src/frame_deframer_crc16_resync_unit.sv]
// Each accepted byte starts a pass: scan for the start pair, check the header, walk
// the CRC and, for a good frame, offer the payload beat by beat, each beat held
// until the consumer takes it. Stall stays high from the accepting edge until the pass
// is done, so no new byte is taken while a pass runs.
// Reset (i_rst_n low, synchronous) empties the buffer, clears the error count
// and restores the start bytes 0xAA/0x55 and a delivery limit of 52.
module frame_deframer_crc16_resync_unit #(
    parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = fdc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_message_type,
    output logic [31:0] o_sequence_number,
    output logic [5:0]  o_frame_payload_length,
    output logic        o_last_byte,
    output logic [31:0] o_crc_error_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import fdc_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] r_sof0, r_sof1;
    logic [5:0] r_limit;

    // Configuration registers; writes are always taken, unknown indexes drop.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof0  <= 8'hAA;
            r_sof1  <= 8'h55;
            r_limit <= 6'd52;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOF0:  r_sof0  <= i_cfg_data;
                CFG_SOF1:  r_sof1  <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    fdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fdc_dpath #(.BUFFER_BYTES(BUFFER_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_rx_byte             (i_rx_byte),
        .i_sof0                (r_sof0),
        .i_sof1                (r_sof1),
        .i_limit               (r_limit),
        .o_payload_byte        (o_payload_byte),
        .o_message_type        (o_message_type),
        .o_sequence_number     (o_sequence_number),
        .o_frame_payload_length(o_frame_payload_length),
        .o_last_byte           (o_last_byte),
        .o_crc_error_total     (o_crc_error_total)
    );
endmodule

[src/fdc_ram.sv]
module fdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/fdc_ctrl.sv]
module fdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  fdc_pkg::t_sts i_sts,
    output fdc_pkg::t_cmd o_cmd
);
    import fdc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (i_sts.pair_hit || i_sts.idx_last) begin
                    n_state = ST_HDR_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_HDR_RD: n_state = i_sts.few_hdr ? ST_IDLE : ST_HDR_CHK;
            ST_HDR_CHK: begin
                if (i_sts.hdr_done) begin
                    if (!i_sts.sane) begin
                        n_state = ST_SCAN_RD;
                    end else if (!i_sts.complete) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_CRC_RD;
                    end
                end else begin
                    n_state = ST_HDR_RD;
                end
            end
            ST_CRC_RD:   n_state = ST_CRC_BYTE;
            ST_CRC_BYTE: n_state = i_sts.crc_done ? ST_CRC_CHK : ST_CRC_RD;
            ST_CRC_CHK: begin
                if (!i_sts.crc_ok) begin
                    n_state = ST_SCAN_RD;
                end else if (i_sts.none_out) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: n_state = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_state = i_sts.out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.push   = i_in_valid;
                o_cmd.idx_clr = i_in_valid;
            end
            ST_SCAN_CHK: begin
                // index points at the second byte of the candidate pair
                if (i_sts.pair_hit) begin
                    o_cmd.drop_idx = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                end else if (i_sts.idx_last) begin
                    o_cmd.drop_idx = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                end else begin
                    o_cmd.cap_prev = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            ST_HDR_CHK: begin
                o_cmd.hdr_cap = 1'b1;
                if (i_sts.hdr_done) begin
                    o_cmd.idx_clr = 1'b1;
                    if (!i_sts.sane) begin
                        o_cmd.drop_one = 1'b1;
                    end else if (i_sts.complete) begin
                        o_cmd.crc_init = 1'b1;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CRC_BYTE: begin
                o_cmd.crc_byte = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            ST_CRC_CHK: begin
                o_cmd.idx_clr = 1'b1;
                if (!i_sts.crc_ok) begin
                    o_cmd.err_inc  = 1'b1;
                    o_cmd.drop_two = 1'b1;
                end else if (i_sts.none_out) begin
                    o_cmd.drop_total = 1'b1;
                end
            end
            ST_OUT_HOLD: begin
                o_out_valid    = 1'b1;
                o_cmd.out_load = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_sts.out_last) o_cmd.drop_total = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

[src/fdc_dpath.sv]
module fdc_dpath #(
    parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = fdc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fdc_pkg::t_cmd i_cmd,
    output fdc_pkg::t_sts o_sts,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_sof0,
    input  logic [7:0]    i_sof1,
    input  logic [5:0]    i_limit,
    output logic [7:0]    o_payload_byte,
    output logic [1:0]    o_message_type,
    output logic [31:0]   o_sequence_number,
    output logic [5:0]    o_frame_payload_length,
    output logic          o_last_byte,
    output logic [31:0]   o_crc_error_total
);
    import fdc_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = $clog2(MAX_PAYLOAD + OVERHEAD_BYTES + 1);
    localparam int TW = (CW > LW) ? CW : LW;
    // Ring storage spans the full pointer range so head arithmetic wraps freely.
    localparam int RAM_DEPTH = 1 << AW;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_idx;
    logic [7:0]    r_prev;
    logic [7:0]    r_ver, r_type, r_lhi;
    logic [31:0]   r_seq;
    logic [15:0]   r_plen;
    logic [15:0]   r_crc;
    logic [15:0]   r_want;
    logic [31:0]   r_err;
    logic [7:0]    r_pay;
    logic          r_last;
    logic [7:0]    rdata;
    logic [AW-1:0] waddr;
    logic          we;
    logic [TW-1:0] total, nout;
    logic [TW-1:0] drop_n;
    logic          drop;
    logic [AW-1:0] rd_addr;
    logic          r_crc_phase, r_out_phase;

    assign total = TW'(r_plen) + TW'(OVERHEAD_BYTES);
    assign nout  = (TW'(r_plen) > TW'(i_limit)) ? TW'(i_limit) : TW'(r_plen);

    // Push with overflow: full buffer drops its oldest byte first.
    assign we    = i_cmd.push;
    assign waddr = (r_count == CW'(BUFFER_BYTES)) ? r_head
                 : AW'(r_head + AW'(r_count));

    always_comb begin
        rd_addr = AW'(r_head + AW'(r_idx));
        if (r_crc_phase) rd_addr = AW'(r_head + AW'(r_idx + TW'(2)));
        if (r_out_phase) rd_addr = AW'(r_head + AW'(r_idx + TW'(HDR_BYTES)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_phase <= 1'b0;
            r_out_phase <= 1'b0;
        end else begin
            if (i_cmd.crc_init) r_crc_phase <= 1'b1;
            if (i_cmd.err_inc || i_cmd.drop_total || (i_cmd.idx_clr && r_crc_phase))
                r_crc_phase <= 1'b0;
            if (r_crc_phase && i_cmd.idx_clr && !i_cmd.err_inc && !i_cmd.drop_total)
                r_out_phase <= 1'b1;
            if (i_cmd.drop_total) r_out_phase <= 1'b0;
        end
    end

    fdc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_rx_byte),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    always_comb begin
        drop   = 1'b1;
        drop_n = '0;
        if (i_cmd.drop_idx) begin
            drop_n = (r_idx == '0) ? TW'(0) : r_idx - (o_sts.pair_hit ? TW'(1) : TW'(0));
        end else if (i_cmd.drop_one) begin
            drop_n = TW'(1);
        end else if (i_cmd.drop_two) begin
            drop_n = TW'(2);
        end else if (i_cmd.drop_total) begin
            drop_n = total;
        end else begin
            drop = 1'b0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push && r_count != CW'(BUFFER_BYTES)) n_count = r_count + CW'(1);
        if (drop) begin
            n_count = (TW'(r_count) <= drop_n) ? '0 : CW'(TW'(r_count) - drop_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_err   <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.push && r_count == CW'(BUFFER_BYTES)) r_head <= AW'(r_head + AW'(1));
            if (drop) begin
                r_head <= (TW'(r_count) <= drop_n) ? AW'(r_head + AW'(r_count))
                                                   : AW'(r_head + AW'(drop_n));
            end
            if (i_cmd.err_inc) r_err <= r_err + 32'd1;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + TW'(1);
            end
        end
    end

    // Header capture, scan history, crc and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_prev) r_prev <= rdata;
        if (i_cmd.idx_clr) r_prev <= 8'h00;
        if (i_cmd.hdr_cap) begin
            case (r_idx)
                TW'(0): r_prev <= rdata;
                TW'(2): r_ver  <= rdata;
                TW'(3): r_type <= rdata;
                TW'(4): r_seq[31:24] <= rdata;
                TW'(5): r_seq[23:16] <= rdata;
                TW'(6): r_seq[15:8]  <= rdata;
                TW'(7): r_seq[7:0]   <= rdata;
                TW'(8): r_lhi <= rdata;
                TW'(9): r_plen <= {r_lhi, rdata};
                default: ;
            endcase
        end
        if (i_cmd.crc_init) r_crc <= CRC_INIT;
        if (i_cmd.crc_byte) begin
            if (r_idx + TW'(2) < total - TW'(2)) begin
                r_crc <= crc_step(r_crc, rdata);
            end else if (r_idx + TW'(2) == total - TW'(2)) begin
                r_want[15:8] <= rdata;
            end else begin
                r_want[7:0] <= rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_pay  <= rdata;
            r_last <= (r_idx + TW'(1) == nout);
        end
    end

    logic first_ok;
    assign first_ok = (r_prev == i_sof0) && (rdata == i_sof1);

    always_comb begin
        o_sts          = '0;
        o_sts.idx_last = (TW'(r_idx) + TW'(1) >= TW'(r_count));
        o_sts.pair_hit = (r_idx != '0) && first_ok;
        o_sts.hdr_done = (r_idx == TW'(HDR_BYTES - 1));
        o_sts.few_hdr  = (r_count < CW'(HDR_BYTES));
        o_sts.sane     = ((r_ver == VER_ONE) || (r_ver == VER_TWO))
                      && (r_type >= TYPE_MIN) && (r_type <= TYPE_MAX)
                      && ({r_lhi, rdata} != 16'd0)
                      && ({r_lhi, rdata} <= 16'(MAX_PAYLOAD));
        o_sts.complete = (TW'(r_count) >= TW'({r_lhi, rdata}) + TW'(OVERHEAD_BYTES));
        // the crc walk ends on the low byte of the received crc
        o_sts.crc_done = (r_idx + TW'(2) == total - TW'(1));
        o_sts.crc_ok   = (r_crc == r_want);
        o_sts.out_last = (r_idx + TW'(1) == nout);
        o_sts.none_out = (nout == '0);
    end

    assign o_payload_byte         = r_out_phase ? rdata : r_pay;
    assign o_message_type         = r_type[1:0];
    assign o_sequence_number      = r_seq;
    assign o_frame_payload_length = r_plen[5:0];
    assign o_last_byte            = r_out_phase ? (r_idx + TW'(1) == nout) : r_last;
    assign o_crc_error_total      = r_err;
endmodule
